[rtl/core/srl_pkg.sv]
// shared types, constants and codes of the stage revision ledger
package srl_pkg;

	localparam int NUM_STAGES = 6;
	localparam int REV_WIDTH  = 32;
	localparam int CNT_WIDTH  = 32;
	localparam int IDX_W      = $clog2(NUM_STAGES);

	typedef logic [REV_WIDTH-1:0] rev_t;
	typedef logic [CNT_WIDTH-1:0] cnt_t;
	typedef logic [IDX_W-1:0]     idx_t;

	typedef enum logic [3:0] {
		OP_REQUEST   = 4'd0,
		OP_ENSURE    = 4'd1,
		OP_RUN       = 4'd2,
		OP_READY     = 4'd3,
		OP_PUBLISH   = 4'd4,
		OP_RETRY     = 4'd5,
		OP_STALE     = 4'd6,
		OP_CANCELLED = 4'd7,
		OP_BASE      = 4'd8,
		OP_QUERY     = 4'd9
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_STAGE  = 3'd1,
		ST_ZERO   = 3'd2,
		ST_TICKET = 3'd3,
		ST_TRANS  = 3'd4,
		ST_FATAL  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		LC_REQUESTED = 3'd0,
		LC_RUNNING   = 3'd1,
		LC_READY     = 3'd2,
		LC_RESIDENT  = 3'd3,
		LC_STALE     = 3'd4,
		LC_CANCELLED = 3'd5
	} life_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [2:0]  stage_index;
		logic [31:0] ticket_revision;
		logic        out_advance;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] issued_revision;
		logic [2:0]  stage_state;
		logic [31:0] requested_rev;
		logic [31:0] output_rev;
		logic [31:0] resident_rev;
		logic        resident_current;
		logic        ticket_current;
		logic [31:0] stale_total;
		logic [31:0] cancelled_total;
	} result_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic result_valid;
	} dp_status_t;

endpackage

[rtl/core/srl_ctrl.sv]
// command sequencer of the stage revision ledger
module srl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output srl_pkg::ctl_cmd_t   cmd,
	input  srl_pkg::dp_status_t dp_status
);

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= EXEC;
						busy_q  <= 1'b1;
					end
				end
				EXEC: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign cmd.load = (state_q == IDLE) && start;
	assign cmd.exec = (state_q == EXEC);

	// an accepted item is executed in the very next cycle
	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("load not followed by exec");

	// exec lasts one cycle and frees the command port
	a_exec_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (!cmd.exec && !busy))
		else $error("exec held or busy stuck");

	// a result strobe only follows an exec cycle
	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		dp_status.result_valid |-> $past(cmd.exec))
		else $error("result without exec");

endmodule

[rtl/core/srl_datapath.sv]
// stage record table, command evaluation and result register
module srl_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srl_pkg::ctl_cmd_t     cmd,
	input  srl_pkg::cmd_item_t    command,
	output srl_pkg::dp_status_t   dp_status,
	output srl_pkg::result_item_t result
);

	srl_pkg::cmd_item_t   cmd_q;
	srl_pkg::life_t       life_q [srl_pkg::NUM_STAGES];
	srl_pkg::rev_t        req_q  [srl_pkg::NUM_STAGES];
	srl_pkg::rev_t        out_q  [srl_pkg::NUM_STAGES];
	srl_pkg::rev_t        res_q  [srl_pkg::NUM_STAGES];
	srl_pkg::cnt_t        stale_q[srl_pkg::NUM_STAGES];
	srl_pkg::cnt_t        canc_q [srl_pkg::NUM_STAGES];
	srl_pkg::result_item_t result_q;
	logic                 valid_q;

	logic                 legal;
	logic                 work;
	srl_pkg::idx_t        idx;
	srl_pkg::rev_t        rev;
	srl_pkg::life_t       rd_life, nx_life;
	srl_pkg::rev_t        rd_req, rd_out, rd_res, nx_req, nx_out, nx_res;
	srl_pkg::cnt_t        rd_stale, rd_canc, nx_stale, nx_canc;
	srl_pkg::status_t     st;
	srl_pkg::rev_t        issued;
	srl_pkg::status_t     tick_st;
	srl_pkg::result_item_t result_d;

	// command latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
		end
	end

	// addressing; publish base always works on stage 0
	always_comb begin
		rev = srl_pkg::rev_t'(cmd_q.ticket_revision);
		if (cmd_q.opcode == srl_pkg::OP_BASE) begin
			legal = 1'b1;
			work  = 1'b0;
			idx   = '0;
		end else begin
			legal = (32'(cmd_q.stage_index) < srl_pkg::NUM_STAGES);
			work  = legal && (cmd_q.stage_index != 3'd0);
			idx   = srl_pkg::idx_t'(cmd_q.stage_index);
		end
	end

	assign rd_life  = life_q[idx];
	assign rd_req   = req_q[idx];
	assign rd_out   = out_q[idx];
	assign rd_res   = res_q[idx];
	assign rd_stale = stale_q[idx];
	assign rd_canc  = canc_q[idx];

	// common ticket check of run, ready, publish and retry
	always_comb begin
		if (!work) begin
			tick_st = srl_pkg::ST_STAGE;
		end else if (rev == '0) begin
			tick_st = srl_pkg::ST_ZERO;
		end else if (rd_req != rev) begin
			tick_st = srl_pkg::ST_TICKET;
		end else begin
			tick_st = srl_pkg::ST_OK;
		end
	end

	// next record and status
	always_comb begin
		nx_life  = rd_life;
		nx_req   = rd_req;
		nx_out   = rd_out;
		nx_res   = rd_res;
		nx_stale = rd_stale;
		nx_canc  = rd_canc;
		st       = srl_pkg::ST_OK;
		issued   = '0;
		case (cmd_q.opcode)
			srl_pkg::OP_REQUEST, srl_pkg::OP_ENSURE: begin
				if (!work) begin
					st = srl_pkg::ST_STAGE;
				end else if (cmd_q.opcode == srl_pkg::OP_ENSURE &&
					rd_life inside {srl_pkg::LC_REQUESTED, srl_pkg::LC_RUNNING,
					srl_pkg::LC_READY}) begin
					issued = rd_req;
				end else if (rd_req == '1) begin
					st = srl_pkg::ST_FATAL;
				end else begin
					nx_req  = rd_req + 1'b1;
					nx_life = srl_pkg::LC_REQUESTED;
					issued  = rd_req + 1'b1;
				end
			end
			srl_pkg::OP_RUN: begin
				st = tick_st;
				if (st == srl_pkg::ST_OK) begin
					if (rd_life == srl_pkg::LC_REQUESTED) begin
						nx_life = srl_pkg::LC_RUNNING;
					end else begin
						st = srl_pkg::ST_TRANS;
					end
				end
			end
			srl_pkg::OP_READY: begin
				st = tick_st;
				if (st == srl_pkg::ST_OK) begin
					if (rd_life == srl_pkg::LC_RUNNING) begin
						nx_life = srl_pkg::LC_READY;
					end else begin
						st = srl_pkg::ST_TRANS;
					end
				end
			end
			srl_pkg::OP_PUBLISH: begin
				st = tick_st;
				if (st == srl_pkg::ST_OK) begin
					if (rd_life != srl_pkg::LC_READY) begin
						st = srl_pkg::ST_TRANS;
					end else if (cmd_q.out_advance && rd_out == '1) begin
						st = srl_pkg::ST_FATAL;
					end else begin
						if (cmd_q.out_advance) begin
							nx_out = rd_out + 1'b1;
						end
						nx_res  = rev;
						nx_life = srl_pkg::LC_RESIDENT;
					end
				end
			end
			srl_pkg::OP_RETRY: begin
				st = tick_st;
				if (st == srl_pkg::ST_OK) begin
					if (rd_life inside {srl_pkg::LC_RUNNING, srl_pkg::LC_READY}) begin
						nx_life = srl_pkg::LC_REQUESTED;
					end else begin
						st = srl_pkg::ST_TRANS;
					end
				end
			end
			srl_pkg::OP_STALE: begin
				if (!work) begin
					st = srl_pkg::ST_STAGE;
				end else if (rev == '0) begin
					st = srl_pkg::ST_ZERO;
				end else if (rd_stale == '1) begin
					st = srl_pkg::ST_FATAL;
				end else begin
					nx_stale = rd_stale + 1'b1;
					if (rd_req == rev) begin
						nx_life = srl_pkg::LC_STALE;
					end
				end
			end
			srl_pkg::OP_CANCELLED: begin
				if (!work) begin
					st = srl_pkg::ST_STAGE;
				end else if (rev == '0) begin
					st = srl_pkg::ST_ZERO;
				end else if (rd_canc == '1) begin
					st = srl_pkg::ST_FATAL;
				end else begin
					nx_canc = rd_canc + 1'b1;
					if (rd_req == rev) begin
						nx_life = srl_pkg::LC_CANCELLED;
					end
				end
			end
			srl_pkg::OP_BASE: begin
				if (rev == '0) begin
					st = srl_pkg::ST_ZERO;
				end else begin
					nx_req  = rev;
					nx_out  = rev;
					nx_res  = rev;
					nx_life = srl_pkg::LC_RESIDENT;
				end
			end
			srl_pkg::OP_QUERY: begin
				st = legal ? srl_pkg::ST_OK : srl_pkg::ST_STAGE;
			end
			default: begin
				st = srl_pkg::ST_TRANS;
			end
		endcase
	end

	// result fields, record after the step
	always_comb begin
		result_d                 = '0;
		result_d.status          = st;
		result_d.issued_revision = 32'(issued);
		if (legal) begin
			result_d.stage_state      = nx_life;
			result_d.requested_rev    = 32'(nx_req);
			result_d.output_rev       = 32'(nx_out);
			result_d.resident_rev     = 32'(nx_res);
			result_d.resident_current = (nx_life == srl_pkg::LC_RESIDENT) &&
				(nx_res == nx_req) && (nx_res != '0) && (nx_out != '0);
			result_d.ticket_current   = (rev != '0) && (nx_req == rev);
			result_d.stale_total      = 32'(nx_stale);
			result_d.cancelled_total  = 32'(nx_canc);
		end
	end

	// record table write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srl_pkg::NUM_STAGES; i++) begin
				life_q[i]  <= srl_pkg::LC_RESIDENT;
				req_q[i]   <= '0;
				out_q[i]   <= '0;
				res_q[i]   <= '0;
				stale_q[i] <= '0;
				canc_q[i]  <= '0;
			end
		end else if (cmd.exec && legal) begin
			life_q[idx]  <= nx_life;
			req_q[idx]   <= nx_req;
			out_q[idx]   <= nx_out;
			res_q[idx]   <= nx_res;
			stale_q[idx] <= nx_stale;
			canc_q[idx]  <= nx_canc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q <= result_d;
		end
	end

	assign dp_status.result_valid = valid_q;
	assign result                 = result_q;

	// a refused command never hands out a revision
	a_no_issue_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (result_q.status != srl_pkg::ST_OK) |-> (result_q.issued_revision == '0))
		else $error("revision issued on refused command");

	// current residency implies the resident state
	a_resident_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.resident_current |->
			(result_q.stage_state == srl_pkg::LC_RESIDENT))
		else $error("resident_current outside resident state");

	// a current ticket needs a nonzero requested revision
	a_ticket_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.ticket_current |-> (result_q.requested_rev != '0))
		else $error("current ticket with zero revision");

endmodule

[rtl/core/stage_revision_ledger_core.sv]
// top level of the stage revision ledger: sequencer plus record datapath
// an accepted item moves the sequencer into its execute state, where the result and its strobe are registered
// a new item is not taken while the previous one is in its execute state
// busy is high for the single execute cycle; start is taken again while a result is strobed
// reset: asynchronous, clears every stage to resident with zero revisions and counts at once
// the result strobe lasts one cycle and the receiver cannot stall it
module stage_revision_ledger_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  srl_pkg::cmd_item_t    command,
	output logic                  result_valid,
	output srl_pkg::result_item_t result
);

	// command and status links between the two halves
	srl_pkg::ctl_cmd_t   ctl_cmd;
	srl_pkg::dp_status_t dp_status;

	// sequencer: idle, then an execute state for each item
	srl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (ctl_cmd),
		.dp_status (dp_status)
	);

	// datapath: latches the item, checks it against the addressed record,
	// writes the record back and registers the result
	srl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.command   (command),
		.dp_status (dp_status),
		.result    (result)
	);

	// strobe comes straight from the result register valid flag
	assign result_valid = dp_status.result_valid;

endmodule
